// File: design/swp_pkg.sv
// Shared types, widths and codes for the serpentine waypoint planner.
// Used by every design file; depends on nothing.
`timescale 1ns / 1ps

package swp_pkg;

  // Grid size defaults
  localparam int unsigned GRID_ROWS_DEF = 6;
  localparam int unsigned GRID_COLS_DEF = 9;

  // Field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned MCODE_W   = 3;
  localparam int unsigned PMODE_W   = 3;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned RADIUS_W  = 14;
  localparam int unsigned SPEED_W   = 11;
  localparam int unsigned SPACING_W = 11;
  localparam int unsigned OFFSET_W  = 15;

  // Datapath widths: waypoint coordinate, multiplier operand and product, squared distance and radius
  localparam int unsigned WP_W   = 20;
  localparam int unsigned MUL_W  = 21;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned DIST_W = PROD_W + 1;
  localparam int unsigned RSQ_W  = 2 * RADIUS_W;

  // Register port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [1:0] REG_ADV_RADIUS = 2'd0;
  localparam logic [1:0] REG_MAX_SPEED  = 2'd1;
  localparam logic [1:0] REG_SPACING    = 2'd2;
  localparam logic [1:0] REG_OFFSET     = 2'd3;

  localparam logic [RADIUS_W-1:0]  ADV_RADIUS_RST = RADIUS_W'(150);
  localparam logic [SPEED_W-1:0]   MAX_SPEED_RST  = SPEED_W'(300);
  localparam logic [SPACING_W-1:0] SPACING_RST    = SPACING_W'(300);
  localparam logic [OFFSET_W-1:0]  OFFSET_RST     = OFFSET_W'(200);

  // Message codes
  localparam logic [OP_W-1:0] OP_STATE   = 3'd0;
  localparam logic [OP_W-1:0] OP_POSE    = 3'd1;
  localparam logic [OP_W-1:0] OP_TARGET  = 3'd2;
  localparam logic [OP_W-1:0] OP_REACHED = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  // Mission codes
  localparam logic [MCODE_W-1:0] MC_HOLD       = 3'd0;
  localparam logic [MCODE_W-1:0] MC_GRID       = 3'd1;
  localparam logic [MCODE_W-1:0] MC_RESCUE     = 3'd2;
  localparam logic [MCODE_W-1:0] MC_MARKER     = 3'd3;
  localparam logic [MCODE_W-1:0] MC_HOME       = 3'd4;
  localparam logic [MCODE_W-1:0] MC_EMERGENCY  = 3'd5;
  localparam logic [MCODE_W-1:0] MC_VERTIPORT  = 3'd6;
  localparam logic [MCODE_W-1:0] MC_SERVO_LAND = 3'd7;

  // Planner modes
  localparam logic [PMODE_W-1:0] PM_HOLD   = 3'd0;
  localparam logic [PMODE_W-1:0] PM_GRID   = 3'd1;
  localparam logic [PMODE_W-1:0] PM_RESCUE = 3'd2;
  localparam logic [PMODE_W-1:0] PM_RETURN = 3'd3;
  localparam logic [PMODE_W-1:0] PM_SERVO  = 3'd4;

  typedef struct packed {
    logic [RADIUS_W-1:0]         advance_radius;
    logic [SPEED_W-1:0]          max_speed;
    logic [SPACING_W-1:0]        grid_spacing;
    logic signed [OFFSET_W-1:0]  grid_offset;
  } cfg_t;

endpackage

// File: design/serpentine_waypoint_planner.sv
// Serpentine coverage waypoint planner: sequencer, state and output register.
// Depends on swp_pkg, swp_cfg_regs and swp_mac.
// A tick outside grid search emits a command directly; in grid search one shared
// multiplier evaluates waypoint coordinates and squared distance in five steps (only
// the coordinates with no pose or a finished grid). Entering grid search with a pose
// scans all waypoints for the nearest one.
// Throughput: one beat at a time; input stalls while the sequencer is busy.
// Reset: sequencer, mission, path index, pose, goal and flags cleared, output
// valid dropped, registers to defaults; working and output data registers not reset.
`timescale 1ns / 1ps

module serpentine_waypoint_planner #(
  parameter int unsigned GRID_ROW_COUNT = swp_pkg::GRID_ROWS_DEF,
  parameter int unsigned GRID_COL_COUNT = swp_pkg::GRID_COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [swp_pkg::OP_W-1:0]            operation_i,
  input  logic [swp_pkg::MCODE_W-1:0]         mission_code_i,
  input  logic signed [swp_pkg::COORD_W-1:0]  pos_x_i,
  input  logic signed [swp_pkg::COORD_W-1:0]  pos_y_i,
  input  logic                                reached_flag_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swp_pkg::COORD_W-1:0]  target_x_o,
  output logic signed [swp_pkg::COORD_W-1:0]  target_y_o,
  output logic [swp_pkg::SPEED_W-1:0]         target_speed_o,
  output logic [swp_pkg::PMODE_W-1:0]         flight_mode_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swp_pkg::PADDR_W-1:0]         paddr,
  input  logic [swp_pkg::PDATA_W-1:0]         pwdata,
  output logic [swp_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned WP_TOTAL = GRID_ROW_COUNT * GRID_COL_COUNT;
  localparam int unsigned IDX_W    = $clog2(WP_TOTAL + 1);
  localparam int unsigned ROW_W    = $clog2(GRID_ROW_COUNT + 1);
  localparam int unsigned COL_W    = $clog2(GRID_COL_COUNT + 1);
  localparam int unsigned CW       = swp_pkg::COORD_W;
  localparam int unsigned WW       = swp_pkg::WP_W;
  localparam int unsigned MW       = swp_pkg::MUL_W;
  localparam int unsigned PW       = swp_pkg::PROD_W;
  localparam int unsigned DW       = swp_pkg::DIST_W;
  localparam int unsigned RW       = swp_pkg::RSQ_W;
  localparam int unsigned SW       = swp_pkg::SPEED_W;

  localparam logic [IDX_W-1:0] IDX_TOTAL = IDX_W'(WP_TOTAL);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WP_TOTAL - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(GRID_COL_COUNT - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RSQ  = 3'd1;
  localparam logic [2:0] S_CX   = 3'd2;
  localparam logic [2:0] S_CY   = 3'd3;
  localparam logic [2:0] S_DX   = 3'd4;
  localparam logic [2:0] S_DY   = 3'd5;
  localparam logic [2:0] S_DS   = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  // Job of the current pass through the sequencer
  localparam logic [1:0] JOB_SCAN  = 2'd0;
  localparam logic [1:0] JOB_TEST  = 2'd1;
  localparam logic [1:0] JOB_COORD = 2'd2;

  localparam logic signed [WW-1:0] SAT_HI = WW'(32767);
  localparam logic signed [WW-1:0] SAT_LO = -(WW'(32768));

  function automatic logic [CW-1:0] sat_coord(input logic signed [WW-1:0] v);
    logic [CW-1:0] r;
    if (v > SAT_HI) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  swp_pkg::cfg_t cfg;

  swp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [2:0]                  state_q, state_d;
  logic [1:0]                  job_q, job_d;
  logic [swp_pkg::MCODE_W-1:0] mission_q, mission_d;
  logic signed [CW-1:0]        pose_x_q, pose_x_d, pose_y_q, pose_y_d;
  logic signed [CW-1:0]        goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic                        has_pose_q, has_pose_d, has_goal_q, has_goal_d;
  logic                        reached_q, reached_d;
  logic [IDX_W-1:0]            idx_q, idx_d, best_idx_q, best_idx_d;
  logic [ROW_W-1:0]            row_q, row_d, best_row_q, best_row_d;
  logic [COL_W-1:0]            pos_q, pos_d, best_pos_q, best_pos_d;
  logic signed [DW-1:0]        best_d_q, best_d_d;
  logic signed [WW-1:0]        wx_q, wx_d, wy_q, wy_d;
  logic signed [PW-1:0]        acc_q, acc_d;
  logic [RW-1:0]               rsq_q, rsq_d;

  logic                        out_valid_q;
  logic [CW-1:0]               out_x_q, out_y_q;
  logic [SW-1:0]               out_speed_q;
  logic [swp_pkg::PMODE_W-1:0] out_mode_q;

  logic                        in_fire, emit_fire;
  logic [COL_W-1:0]            col;
  logic [ROW_W-1:0]            step_row;
  logic [COL_W-1:0]            step_pos;
  logic signed [MW-1:0]        mul_a, mul_b, dx, dy;
  logic signed [PW-1:0]        prod;
  logic signed [DW-1:0]        dsq, rsq_ext;
  logic                        better;
  logic [IDX_W-1:0]            idx_inc;
  logic [SW+1:0]               speed_x3;
  logic [SW+18:0]              speed_div;
  logic [SW-1:0]               servo_speed;
  logic [CW-1:0]               emit_x, emit_y;
  logic [SW-1:0]               emit_speed;
  logic [swp_pkg::PMODE_W-1:0] emit_mode;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign emit_fire  = (state_q == S_EMIT) & (~out_valid_q | ~out_stall_i);

  // Serpentine column and the next cell along the path
  assign col = row_q[0] ? (COL_LAST - pos_q) : pos_q;
  always_comb begin
    if (pos_q == COL_LAST) begin
      step_row = row_q + ROW_W'(1);
      step_pos = '0;
    end else begin
      step_row = row_q;
      step_pos = pos_q + COL_W'(1);
    end
  end

  assign dx = {{(MW-CW){pose_x_q[CW-1]}}, pose_x_q} - {{(MW-WW){wx_q[WW-1]}}, wx_q};
  assign dy = {{(MW-CW){pose_y_q[CW-1]}}, pose_y_q} - {{(MW-WW){wy_q[WW-1]}}, wy_q};

  always_comb begin
    unique case (state_q)
      S_RSQ: begin
        mul_a = MW'(cfg.advance_radius);
        mul_b = MW'(cfg.advance_radius);
      end
      S_CX: begin
        mul_a = MW'(col);
        mul_b = MW'(cfg.grid_spacing);
      end
      S_CY: begin
        mul_a = MW'(row_q);
        mul_b = MW'(cfg.grid_spacing);
      end
      S_DX: begin
        mul_a = dx;
        mul_b = dx;
      end
      S_DY: begin
        mul_a = dy;
        mul_b = dy;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  swp_mac u_mac (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign dsq     = {acc_q[PW-1], acc_q} + {prod[PW-1], prod};
  assign rsq_ext = {{(DW-RW){1'b0}}, rsq_q};
  assign better  = (idx_q == '0) || (dsq < best_d_q);
  assign idx_inc = idx_q + IDX_W'(1);

  // Servo speed: floor(max*3/10) by reciprocal 52429 / 2^19, exact below 2^16
  assign speed_x3    = {2'b00, cfg.max_speed} + {1'b0, cfg.max_speed, 1'b0};
  assign speed_div   = speed_x3 * 17'd52429;
  assign servo_speed = speed_div[SW+18:19];

  always_comb begin
    unique case (mission_q)
      swp_pkg::MC_GRID: begin
        emit_x     = sat_coord(wx_q);
        emit_y     = sat_coord(wy_q);
        emit_speed = cfg.max_speed;
        emit_mode  = swp_pkg::PM_GRID;
      end
      swp_pkg::MC_RESCUE, swp_pkg::MC_MARKER: begin
        emit_x     = has_goal_q ? goal_x_q : pose_x_q;
        emit_y     = has_goal_q ? goal_y_q : pose_y_q;
        emit_speed = (mission_q == swp_pkg::MC_RESCUE && reached_q) ? '0 : cfg.max_speed;
        emit_mode  = swp_pkg::PM_RESCUE;
      end
      swp_pkg::MC_HOME, swp_pkg::MC_EMERGENCY: begin
        emit_x     = '0;
        emit_y     = '0;
        emit_speed = cfg.max_speed;
        emit_mode  = swp_pkg::PM_RETURN;
      end
      swp_pkg::MC_VERTIPORT, swp_pkg::MC_SERVO_LAND: begin
        emit_x     = has_goal_q ? goal_x_q : pose_x_q;
        emit_y     = has_goal_q ? goal_y_q : pose_y_q;
        emit_speed = servo_speed;
        emit_mode  = swp_pkg::PM_SERVO;
      end
      default: begin
        emit_x     = pose_x_q;
        emit_y     = pose_y_q;
        emit_speed = '0;
        emit_mode  = swp_pkg::PM_HOLD;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    mission_d  = mission_q;
    pose_x_d   = pose_x_q;
    pose_y_d   = pose_y_q;
    goal_x_d   = goal_x_q;
    goal_y_d   = goal_y_q;
    has_pose_d = has_pose_q;
    has_goal_d = has_goal_q;
    reached_d  = reached_q;
    idx_d      = idx_q;
    row_d      = row_q;
    pos_d      = pos_q;
    best_idx_d = best_idx_q;
    best_row_d = best_row_q;
    best_pos_d = best_pos_q;
    best_d_d   = best_d_q;
    wx_d       = wx_q;
    wy_d       = wy_q;
    acc_d      = acc_q;
    rsq_d      = rsq_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (operation_i)
            swp_pkg::OP_STATE: begin
              mission_d = mission_code_i;
              if (mission_code_i == swp_pkg::MC_GRID && mission_q != swp_pkg::MC_GRID) begin
                idx_d = '0;
                row_d = '0;
                pos_d = '0;
                if (has_pose_q) begin
                  job_d   = JOB_SCAN;
                  state_d = S_CX;
                end
              end
            end
            swp_pkg::OP_POSE: begin
              pose_x_d   = pos_x_i;
              pose_y_d   = pos_y_i;
              has_pose_d = 1'b1;
            end
            swp_pkg::OP_TARGET: begin
              goal_x_d   = pos_x_i;
              goal_y_d   = pos_y_i;
              has_goal_d = 1'b1;
            end
            swp_pkg::OP_REACHED: begin
              reached_d = reached_flag_i;
            end
            swp_pkg::OP_TICK: begin
              if (mission_q == swp_pkg::MC_GRID) begin
                if (has_pose_q && idx_q < IDX_TOTAL) begin
                  job_d   = JOB_TEST;
                  state_d = S_RSQ;
                end else begin
                  job_d   = JOB_COORD;
                  state_d = S_CX;
                end
              end else begin
                state_d = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RSQ: begin
        state_d = S_CX;
      end
      S_CX: begin
        // radius squared lands here on a reach test
        if (job_q == JOB_TEST) begin
          rsq_d = prod[RW-1:0];
        end
        state_d = S_CY;
      end
      S_CY: begin
        wx_d    = {{(WW-swp_pkg::OFFSET_W){cfg.grid_offset[swp_pkg::OFFSET_W-1]}},
                   cfg.grid_offset} + prod[WW-1:0];
        state_d = S_DX;
      end
      S_DX: begin
        wy_d    = WW'(0) - prod[WW-1:0];
        state_d = (job_q == JOB_COORD) ? S_EMIT : S_DY;
      end
      S_DY: begin
        acc_d   = prod;
        state_d = S_DS;
      end
      S_DS: begin
        if (job_q == JOB_SCAN) begin
          if (idx_q == IDX_LAST) begin
            // settle on the nearest; current cell wins only when strictly closer
            if (!better) begin
              idx_d = best_idx_q;
              row_d = best_row_q;
              pos_d = best_pos_q;
            end
            state_d = S_IDLE;
          end else begin
            if (better) begin
              best_idx_d = idx_q;
              best_row_d = row_q;
              best_pos_d = pos_q;
              best_d_d   = dsq;
            end
            idx_d   = idx_inc;
            row_d   = step_row;
            pos_d   = step_pos;
            state_d = S_CX;
          end
        end else begin
          if (dsq < rsq_ext) begin
            idx_d = idx_inc;
            // hold the last cell once the path is done
            if (idx_inc < IDX_TOTAL) begin
              row_d = step_row;
              pos_d = step_pos;
            end
            job_d   = JOB_COORD;
            state_d = S_CX;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      default: begin
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      job_q      <= JOB_SCAN;
      mission_q  <= swp_pkg::MC_HOLD;
      pose_x_q   <= '0;
      pose_y_q   <= '0;
      goal_x_q   <= '0;
      goal_y_q   <= '0;
      has_pose_q <= 1'b0;
      has_goal_q <= 1'b0;
      reached_q  <= 1'b0;
      idx_q      <= '0;
      row_q      <= '0;
      pos_q      <= '0;
    end else begin
      state_q    <= state_d;
      job_q      <= job_d;
      mission_q  <= mission_d;
      pose_x_q   <= pose_x_d;
      pose_y_q   <= pose_y_d;
      goal_x_q   <= goal_x_d;
      goal_y_q   <= goal_y_d;
      has_pose_q <= has_pose_d;
      has_goal_q <= has_goal_d;
      reached_q  <= reached_d;
      idx_q      <= idx_d;
      row_q      <= row_d;
      pos_q      <= pos_d;
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_row_q <= best_row_d;
    best_pos_q <= best_pos_d;
    best_d_q   <= best_d_d;
    wx_q       <= wx_d;
    wy_q       <= wy_d;
    acc_q      <= acc_d;
    rsq_q      <= rsq_d;
  end

  // Output register: load on emit, drop once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_x_q     <= emit_x;
      out_y_q     <= emit_y;
      out_speed_q <= emit_speed;
      out_mode_q  <= emit_mode;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign target_x_o     = out_x_q;
  assign target_y_o     = out_y_q;
  assign target_speed_o = out_speed_q;
  assign flight_mode_o  = out_mode_q;

endmodule

// File: design/swp_cfg_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on swp_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module swp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swp_pkg::PADDR_W-1:0]  paddr,
  input  logic [swp_pkg::PDATA_W-1:0]  pwdata,
  output logic [swp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output swp_pkg::cfg_t                cfg_o
);

  swp_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.advance_radius <= swp_pkg::ADV_RADIUS_RST;
      cfg_q.max_speed      <= swp_pkg::MAX_SPEED_RST;
      cfg_q.grid_spacing   <= swp_pkg::SPACING_RST;
      cfg_q.grid_offset    <= swp_pkg::OFFSET_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        swp_pkg::REG_ADV_RADIUS: cfg_q.advance_radius <= pwdata[swp_pkg::RADIUS_W-1:0];
        swp_pkg::REG_MAX_SPEED:  cfg_q.max_speed      <= pwdata[swp_pkg::SPEED_W-1:0];
        swp_pkg::REG_SPACING:    cfg_q.grid_spacing   <= pwdata[swp_pkg::SPACING_W-1:0];
        swp_pkg::REG_OFFSET:     cfg_q.grid_offset    <= pwdata[swp_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      swp_pkg::REG_ADV_RADIUS:
        prdata = {{(swp_pkg::PDATA_W-swp_pkg::RADIUS_W){1'b0}}, cfg_q.advance_radius};
      swp_pkg::REG_MAX_SPEED:
        prdata = {{(swp_pkg::PDATA_W-swp_pkg::SPEED_W){1'b0}}, cfg_q.max_speed};
      swp_pkg::REG_SPACING:
        prdata = {{(swp_pkg::PDATA_W-swp_pkg::SPACING_W){1'b0}}, cfg_q.grid_spacing};
      default:
        prdata = {{(swp_pkg::PDATA_W-swp_pkg::OFFSET_W){cfg_q.grid_offset[swp_pkg::OFFSET_W-1]}},
                  cfg_q.grid_offset};
    endcase
  end

endmodule

// File: design/swp_mac.sv
// Shared signed multiplier with a registered product.
// Depends on swp_pkg for operand and product widths.
`timescale 1ns / 1ps

module swp_mac (
  input  logic                               clk_i,
  input  logic signed [swp_pkg::MUL_W-1:0]   a_i,
  input  logic signed [swp_pkg::MUL_W-1:0]   b_i,
  output logic signed [swp_pkg::PROD_W-1:0]  prod_o
);

  logic signed [swp_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// File: bench/swp_plan_checker.sv
// Checker for the serpentine waypoint planner: follows register writes and input beats,
// predicts each planner command and compares it with the command beat the block sends.
// Depends on swp_pkg.
`timescale 1ns / 1ps

module swp_plan_checker import swp_pkg::*; #(
  parameter int unsigned ROWS = GRID_ROWS_DEF,
  parameter int unsigned COLS = GRID_COLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [OP_W-1:0]            operation_i,
  input  logic [MCODE_W-1:0]         mission_code_i,
  input  logic signed [COORD_W-1:0]  pos_x_i,
  input  logic signed [COORD_W-1:0]  pos_y_i,
  input  logic                       reached_flag_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [COORD_W-1:0]  target_x_i,
  input  logic signed [COORD_W-1:0]  target_y_i,
  input  logic [SPEED_W-1:0]         target_speed_i,
  input  logic [PMODE_W-1:0]         flight_mode_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  input  logic                       pready,
  output int                         fail_count_o,
  output int                         pending_count_o,
  output int                         checked_count_o
);

  localparam int unsigned WAYPOINTS = ROWS * COLS;
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  // Servo speed is three tenths of cruise speed, truncated
  localparam int SERVO_NUM = 3;
  localparam int SERVO_DEN = 10;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SPEED_W-1:0]        speed;
    logic [PMODE_W-1:0]        mode;
  } command_t;

  cfg_t                      cfg;
  logic [MCODE_W-1:0]        mission;
  logic signed [COORD_W-1:0] pose_x;
  logic signed [COORD_W-1:0] pose_y;
  logic signed [COORD_W-1:0] goal_x;
  logic signed [COORD_W-1:0] goal_y;
  bit                        has_pose;
  bit                        has_goal;
  bit                        goal_hit;
  int unsigned               wp_index;
  command_t                  pending_commands[$];
  int                        fails = 0;
  int                        checked = 0;

  function automatic void waypoint_xy(input int unsigned i, output longint wx,
                                      output longint wy);
    int unsigned row;
    int unsigned col;
    row = i / COLS;
    col = (row % 2 == 1) ? COLS - 1 - i % COLS : i % COLS;
    wx = longint'($signed(cfg.grid_offset)) + longint'(col) * longint'(cfg.grid_spacing);
    wy = -(longint'(row) * longint'(cfg.grid_spacing));
  endfunction

  function automatic longint dist_sq(input int unsigned i);
    longint wx;
    longint wy;
    longint dx;
    longint dy;
    waypoint_xy(i, wx, wy);
    dx = longint'(pose_x) - wx;
    dy = longint'(pose_y) - wy;
    return dx * dx + dy * dy;
  endfunction

  // First waypoint of least squared distance; ties keep the earlier one
  function automatic int unsigned nearest_waypoint();
    int unsigned best;
    longint best_d;
    longint d;
    best = 0;
    best_d = 0;
    if (!has_pose) return 0;
    for (int unsigned i = 0; i < WAYPOINTS; i++) begin
      d = dist_sq(i);
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return COORD_W'(v);
  endfunction

  // Advance the waypoint index where due and build the command for one tick
  function automatic command_t plan_tick();
    command_t c;
    longint tx;
    longint ty;
    longint r2;
    int unsigned shown;
    c.speed = cfg.max_speed;
    case (mission)
      MC_GRID: begin
        r2 = longint'(cfg.advance_radius) * longint'(cfg.advance_radius);
        if (has_pose && wp_index < WAYPOINTS && dist_sq(wp_index) < r2) wp_index++;
        // a finished grid keeps pointing at the last waypoint
        shown = (wp_index < WAYPOINTS) ? wp_index : WAYPOINTS - 1;
        waypoint_xy(shown, tx, ty);
        c.mode = PM_GRID;
      end
      MC_RESCUE, MC_MARKER: begin
        tx = has_goal ? goal_x : pose_x;
        ty = has_goal ? goal_y : pose_y;
        if (mission == MC_RESCUE && goal_hit) c.speed = '0;
        c.mode = PM_RESCUE;
      end
      MC_HOME, MC_EMERGENCY: begin
        tx = 0;
        ty = 0;
        c.mode = PM_RETURN;
      end
      MC_VERTIPORT, MC_SERVO_LAND: begin
        tx = has_goal ? goal_x : pose_x;
        ty = has_goal ? goal_y : pose_y;
        c.speed = SPEED_W'((int'(cfg.max_speed) * SERVO_NUM) / SERVO_DEN);
        c.mode = PM_SERVO;
      end
      default: begin
        tx = pose_x;
        ty = pose_y;
        c.speed = '0;
        c.mode = PM_HOLD;
      end
    endcase
    c.x = sat_coord(tx);
    c.y = sat_coord(ty);
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    command_t exp_cmd;
    if (!rst_ni) begin
      cfg.advance_radius = ADV_RADIUS_RST;
      cfg.max_speed = MAX_SPEED_RST;
      cfg.grid_spacing = SPACING_RST;
      cfg.grid_offset = OFFSET_RST;
      mission = MC_HOLD;
      pose_x = '0;
      pose_y = '0;
      goal_x = '0;
      goal_y = '0;
      has_pose = 1'b0;
      has_goal = 1'b0;
      goal_hit = 1'b0;
      wp_index = 0;
      pending_commands.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_ADV_RADIUS: cfg.advance_radius = pwdata[RADIUS_W-1:0];
          REG_MAX_SPEED:  cfg.max_speed = pwdata[SPEED_W-1:0];
          REG_SPACING:    cfg.grid_spacing = pwdata[SPACING_W-1:0];
          REG_OFFSET:     cfg.grid_offset = pwdata[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (operation_i)
          OP_STATE: begin
            if (mission_code_i == MC_GRID && mission != MC_GRID) wp_index = nearest_waypoint();
            mission = mission_code_i;
          end
          OP_POSE: begin
            pose_x = pos_x_i;
            pose_y = pos_y_i;
            has_pose = 1'b1;
          end
          OP_TARGET: begin
            goal_x = pos_x_i;
            goal_y = pos_y_i;
            has_goal = 1'b1;
          end
          OP_REACHED: goal_hit = reached_flag_i;
          OP_TICK: pending_commands.insert(pending_commands.size(), plan_tick());
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_commands.size() == 0) begin
          $error("command beat with nothing expected: x %0d y %0d speed %0d mode %0d",
                 target_x_i, target_y_i, target_speed_i, flight_mode_i);
          fails++;
        end else begin
          exp_cmd = pending_commands.pop_front();
          checked++;
          if (target_x_i !== exp_cmd.x) begin
            $error("target_x: expected %0d, got %0d", exp_cmd.x, target_x_i);
            fails++;
          end
          if (target_y_i !== exp_cmd.y) begin
            $error("target_y: expected %0d, got %0d", exp_cmd.y, target_y_i);
            fails++;
          end
          if (target_speed_i !== exp_cmd.speed) begin
            $error("target_speed: expected %0d, got %0d", exp_cmd.speed, target_speed_i);
            fails++;
          end
          if (flight_mode_i !== exp_cmd.mode) begin
            $error("flight_mode: expected %0d, got %0d", exp_cmd.mode, flight_mode_i);
            fails++;
          end
        end
      end
    end
    // commands still owed are reported separately through the pending count
    fail_count_o <= fails;
    pending_count_o <= pending_commands.size();
    checked_count_o <= checked;
  end

endmodule

// File: bench/testbench.sv
// Top of the serpentine waypoint planner bench: clock, reset, register writes,
// directed and random message beats, random stalls and the final verdict.
// Depends on swp_pkg, serpentine_waypoint_planner and swp_plan_checker.
`timescale 1ns / 1ps

module testbench;
  import swp_pkg::*;

  localparam int unsigned ROWS = GRID_ROWS_DEF;
  localparam int unsigned COLS = GRID_COLS_DEF;
  localparam int WAYPOINTS = ROWS * COLS;
  // a grid entry scans every waypoint in five steps
  localparam int SETTLE_CYCLES = 5 * ROWS * COLS + 20;
  localparam int TOTAL_BEATS = 1950;
  localparam int PHASES = 10;
  localparam int MAX_WAIT = 19;
  localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_W - 1));
  localparam int OP_LAST = 2 ** OP_W - 1;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [OP_W-1:0]           operation;
  logic [MCODE_W-1:0]        mission_code;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic                      reached_flag;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic [SPEED_W-1:0]        target_speed;
  logic [PMODE_W-1:0]        flight_mode;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  int fail_count;
  int pending_count;
  int checked_count;
  int beat_count;
  int settings_count;
  bit sender_idles;
  bit sink_idles;
  int cur_radius;
  int cur_spacing;
  int cur_offset;

  serpentine_waypoint_planner #(
    .GRID_ROW_COUNT(ROWS),
    .GRID_COL_COUNT(COLS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .mission_code_i(mission_code),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .reached_flag_i(reached_flag),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .target_x_o    (target_x),
    .target_y_o    (target_y),
    .target_speed_o(target_speed),
    .flight_mode_o (flight_mode),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  swp_plan_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) plan_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .mission_code_i (mission_code),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .reached_flag_i (reached_flag),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .target_x_i     (target_x),
    .target_y_i     (target_y),
    .target_speed_i (target_speed),
    .flight_mode_i  (flight_mode),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count),
    .checked_count_o(checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Command sink: stall a random number of cycles before taking each beat
  initial begin
    int wait_cycles;
    int served;
    out_stall = 1'b0;
    served = 0;
    sink_idles = 1'b1;
    @(posedge rst_n);
    forever begin
      if (served % 40 == 0) sink_idles = ($urandom_range(0, 3) != 0);
      wait_cycles = sink_idles ? $urandom_range(0, MAX_WAIT) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  function automatic int clamp_coord(input int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 2 ** COORD_W - 1)) + COORD_MIN;
  endfunction

  // Pose inside the advance radius of waypoint k, or exactly on its rim
  function automatic void near_waypoint(input int k, input bit on_rim, output int x,
                                        output int y);
    int row;
    int col;
    int reach;
    row = k / COLS;
    col = (row % 2 == 1) ? COLS - 1 - k % COLS : k % COLS;
    reach = cur_radius / 2;
    if (on_rim) begin
      x = clamp_coord(cur_offset + col * cur_spacing + cur_radius);
      y = clamp_coord(-row * cur_spacing);
    end else begin
      x = clamp_coord(cur_offset + col * cur_spacing + int'($urandom_range(0, 2 * reach))
                      - reach);
      y = clamp_coord(-row * cur_spacing + int'($urandom_range(0, 2 * reach)) - reach);
    end
  endfunction

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [MCODE_W-1:0] code,
                           input int x, input int y, input logic flag);
    int gap;
    if (beat_count % 40 == 0) sender_idles = ($urandom_range(0, 3) != 0);
    gap = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    mission_code <= code;
    pos_x <= COORD_W'(x);
    pos_y <= COORD_W'(y);
    reached_flag <= flag;
    do @(posedge clk); while (in_stall);
    if (op <= OP_TICK) beat_count++;
  endtask

  // Drop valid and hold until every command owed has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int radius, input int speed, input int spacing,
                                input int offset);
    quiesce();
    write_reg(REG_ADV_RADIUS, radius);
    write_reg(REG_MAX_SPEED, speed);
    write_reg(REG_SPACING, spacing);
    write_reg(REG_OFFSET, offset);
    cur_radius = radius;
    cur_spacing = spacing;
    cur_offset = offset;
    settings_count++;
  endtask

  // Leave grid search, enter it near a waypoint, then follow the serpentine
  task automatic walk_grid();
    int first;
    int steps;
    int k;
    int at;
    int x;
    int y;
    logic [MCODE_W-1:0] code;
    first = ($urandom_range(0, 3) == 0) ? $urandom_range(WAYPOINTS - 8, WAYPOINTS - 1)
                                        : $urandom_range(0, WAYPOINTS - 1);
    steps = $urandom_range(3, 20);
    code = MCODE_W'($urandom_range(MC_HOLD, MC_SERVO_LAND));
    if (code == MC_GRID) code = MC_HOLD;
    send_beat(OP_STATE, code, rand_coord(), rand_coord(), 1'($urandom));
    near_waypoint(first, 1'b0, x, y);
    send_beat(OP_POSE, MCODE_W'($urandom), x, y, 1'($urandom));
    send_beat(OP_STATE, MC_GRID, rand_coord(), rand_coord(), 1'($urandom));
    for (k = first; k < first + steps; k++) begin
      at = (k < WAYPOINTS) ? k : WAYPOINTS - 1;
      if ($urandom_range(0, 7) == 0) begin
        near_waypoint(at, 1'b1, x, y);
        send_beat(OP_POSE, MCODE_W'($urandom), x, y, 1'($urandom));
        send_beat(OP_TICK, MCODE_W'($urandom), rand_coord(), rand_coord(), 1'($urandom));
      end
      near_waypoint(at, 1'b0, x, y);
      send_beat(OP_POSE, MCODE_W'($urandom), x, y, 1'($urandom));
      send_beat(OP_TICK, MCODE_W'($urandom), rand_coord(), rand_coord(), 1'($urandom));
    end
  endtask

  task automatic random_beat();
    int pick;
    int x;
    int y;
    logic [MCODE_W-1:0] code;
    logic flag;
    pick = $urandom_range(0, 99);
    x = rand_coord();
    y = rand_coord();
    code = MCODE_W'($urandom);
    flag = 1'($urandom);
    if (pick < 5) begin
      send_beat(OP_W'($urandom_range(OP_TICK + 1, OP_LAST)), code, x, y, flag);
    end else if (pick < 20) begin
      send_beat(OP_STATE, (pick < 10) ? MC_GRID : code, x, y, flag);
    end else if (pick < 40) begin
      if (pick < 30) near_waypoint($urandom_range(0, WAYPOINTS - 1), 1'b0, x, y);
      send_beat(OP_POSE, code, x, y, flag);
    end else if (pick < 48) begin
      send_beat(OP_TARGET, code, x, y, flag);
    end else if (pick < 56) begin
      send_beat(OP_REACHED, code, x, y, flag);
    end else begin
      send_beat(OP_TICK, code, x, y, flag);
    end
  endtask

  task automatic run_phase(input int beats);
    int stop;
    stop = beat_count + beats;
    while (beat_count < stop) begin
      if ($urandom_range(0, 149) == 0) drain_results();
      if ($urandom_range(0, 9) < 6) walk_grid();
      else random_beat();
    end
  endtask

  initial begin
    int spread;
    rst_n = 1'b0;
    in_valid = 1'b0;
    operation = OP_STATE;
    mission_code = MC_HOLD;
    pos_x = '0;
    pos_y = '0;
    reached_flag = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    beat_count = 0;
    settings_count = 0;
    sender_idles = 1'b1;
    cur_radius = ADV_RADIUS_RST;
    cur_spacing = SPACING_RST;
    cur_offset = int'($signed(OFFSET_RST));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass on reset settings
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_STATE, MC_GRID, 0, 0, 1'b0);          // enter grid with no pose
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_POSE, MC_HOLD, 200, 0, 1'b0);         // right on the first waypoint
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_POSE, MC_HOLD, COORD_MAX, COORD_MIN, 1'b0);
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_STATE, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_POSE, MC_HOLD, 2600, -1500, 1'b0);    // start of the last row
    send_beat(OP_STATE, MC_GRID, 0, 0, 1'b0);
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_STATE, MC_GRID, 0, 0, 1'b0);          // grid to grid keeps the index
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_STATE, MC_RESCUE, 0, 0, 1'b0);
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);           // no goal yet
    send_beat(OP_TARGET, MC_HOLD, COORD_MIN, COORD_MAX, 1'b0);
    send_beat(OP_REACHED, MC_HOLD, 0, 0, 1'b1);
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_STATE, MC_MARKER, 0, 0, 1'b0);
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_STATE, MC_HOME, 0, 0, 1'b0);
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_STATE, MC_SERVO_LAND, 0, 0, 1'b0);
    send_beat(OP_TICK, MC_HOLD, 0, 0, 1'b0);
    send_beat(OP_W'(OP_LAST), MC_SERVO_LAND, COORD_MAX, COORD_MAX, 1'b1);

    spread = (TOTAL_BEATS - beat_count) / PHASES;
    apply_settings(1000, 1500, 400, -1000);
    run_phase(spread);
    apply_settings(0, 0, 1, -10000);
    run_phase(spread);
    apply_settings(10000, 2000, 2000, 10000);
    run_phase(spread);
    apply_settings(2 ** RADIUS_W - 1, 2 ** SPEED_W - 1, 2 ** SPACING_W - 1,
                   -(2 ** (OFFSET_W - 1)));
    run_phase(spread);
    apply_settings(200, 700, 0, 5000);                 // all waypoints of a row coincide
    run_phase(spread);
    repeat (4) begin
      apply_settings($urandom_range(0, 10000), $urandom_range(0, 2000),
                     $urandom_range(1, 2000), int'($urandom_range(0, 20000)) - 10000);
      run_phase(spread);
    end
    apply_settings(ADV_RADIUS_RST, MAX_SPEED_RST, SPACING_RST, int'($signed(OFFSET_RST)));
    run_phase(TOTAL_BEATS - beat_count);
    quiesce();

    $display("Sent %0d message beats under %0d register settings plus reset defaults;",
             beat_count, settings_count);
    $display("checked %0d planner commands, %0d mismatches.", checked_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/swp_pkg.sv
design/swp_cfg_regs.sv
design/swp_mac.sv
design/serpentine_waypoint_planner.sv
bench/swp_plan_checker.sv
bench/testbench.sv
